// File: hw/rtl/snoop_filter_presence_table_defines.svh
// assertion macros for the snoop filter presence table
`ifndef SNOOP_FILTER_PRESENCE_TABLE_DEFINES_SVH
`define SNOOP_FILTER_PRESENCE_TABLE_DEFINES_SVH

// condition must never hold outside reset
`define SFPT_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("sfpt never violated");

// antecedent implies consequent in the same cycle
`define SFPT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfpt same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define SFPT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfpt next-cycle implication violated");

`endif

// File: hw/rtl/sfpt_pkg.sv
// shared types and constants of the snoop filter presence table
`timescale 1ns / 1ps
`default_nettype none
package sfpt_pkg;
   localparam int ADDR_W  = 32;
   localparam int AGE_W   = 32;
   localparam int TYPE_W  = 3;
   localparam int SHIFT_W = 5;
   localparam int PRES_W  = 4;

   localparam logic [SHIFT_W-1:0] TAG_SHIFT_RST = 5'd6;

   localparam logic [TYPE_W-1:0] REQ_LOAD_MISS  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_STORE_MISS = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_READ_HIT   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_WRITE_UPG  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_LOOKUP     = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic rd;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic rsp_busy;
   } sts_type;
endpackage
`default_nettype wire

// File: hw/rtl/sfpt_ctrl.sv
// controller state machine of the snoop filter presence table
`timescale 1ns / 1ps
`default_nettype none
module sfpt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire sfpt_pkg::sts_type sts,
   output sfpt_pkg::cmd_type     cmd
);
   sfpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfpt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfpt_pkg::ST_CLEAR: if (sts.last) state_in = sfpt_pkg::ST_IDLE;
         sfpt_pkg::ST_IDLE:  if (req_tvalid) state_in = sfpt_pkg::ST_SCAN;
         sfpt_pkg::ST_SCAN:  if (sts.last) state_in = sfpt_pkg::ST_DRAIN;
         sfpt_pkg::ST_DRAIN: state_in = sfpt_pkg::ST_FINAL;
         sfpt_pkg::ST_FINAL: if (!sts.rsp_busy) state_in = sfpt_pkg::ST_IDLE;
         default:            state_in = sfpt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sfpt_pkg::ST_CLEAR: cmd.clr = 1'b1;
         sfpt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sfpt_pkg::ST_SCAN:  cmd.rd = 1'b1;
         sfpt_pkg::ST_FINAL: cmd.fin = !sts.rsp_busy;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: hw/rtl/sfpt_dp.sv
// table memory, scan trackers and response register of the snoop filter
`timescale 1ns / 1ps
`default_nettype none
module sfpt_dp #(
   parameter int ENTRIES = 64,
   parameter int CORES   = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sfpt_pkg::cmd_type             cmd,
   output sfpt_pkg::sts_type                  sts,
   input  wire logic [sfpt_pkg::TYPE_W-1:0]   in_type,
   input  wire logic [1:0]                    in_requester,
   input  wire logic [sfpt_pkg::ADDR_W-1:0]   in_line_addr,
   input  wire logic                          in_writeback,
   input  wire logic                          csr_we,
   input  wire logic [sfpt_pkg::SHIFT_W-1:0]  csr_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic [sfpt_pkg::PRES_W-1:0]        rsp_presence
);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int AW    = sfpt_pkg::ADDR_W;
   localparam int GW    = sfpt_pkg::AGE_W;
   localparam int REC_W = AW + CORES + GW;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [REC_W-1:0] mem [ENTRIES];
   logic [REC_W-1:0] rd_ff;

   logic [IDX_W-1:0] idx_ff, pidx_ff;
   logic             rvalid_ff;
   logic [sfpt_pkg::SHIFT_W-1:0] shift_ff;

   // captured transaction
   logic [sfpt_pkg::TYPE_W-1:0] type_ff;
   logic [CORES-1:0]            bit_ff;
   logic [AW-1:0]               line_ff;
   logic                        wb_ff;

   // scan trackers
   logic             hit_ff, emp_ff;
   logic [IDX_W-1:0] hit_idx_ff, emp_idx_ff, best_idx_ff;
   logic [CORES-1:0] hit_pres_ff;
   logic [GW-1:0]    hit_age_ff, best_ff;

   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [sfpt_pkg::PRES_W-1:0] rsp_pres_ff;

   logic [AW-1:0]    r_addr;
   logic [CORES-1:0] r_pres, p2;
   logic [GW-1:0]    r_age, g2;
   logic             is_miss, wipe, match;

   logic             we;
   logic [IDX_W-1:0] wa;
   logic [REC_W-1:0] wd;
   logic [CORES-1:0] new_pres;
   logic [GW-1:0]    new_age;
   logic [IDX_W-1:0] victim;

   assign is_miss = (type_ff == sfpt_pkg::REQ_LOAD_MISS) ||
                    (type_ff == sfpt_pkg::REQ_STORE_MISS);

   assign {r_addr, r_pres, r_age} = rd_ff;
   assign match = (r_pres != '0) && (r_addr == line_ff);
   assign wipe  = is_miss && wb_ff && (r_addr != line_ff) &&
                  ((r_addr >> shift_ff) == (line_ff >> shift_ff));

   always_comb begin
      p2 = wipe ? (r_pres & ~bit_ff) : r_pres;
      g2 = r_age;
      if (is_miss && (p2 != '0) && (r_age != {GW{1'b1}})) g2 = r_age + 1'b1;
   end

   always_comb begin
      if ((type_ff == sfpt_pkg::REQ_LOAD_MISS) || (type_ff == sfpt_pkg::REQ_READ_HIT)) begin
         new_pres = hit_pres_ff | bit_ff;
      end else begin
         new_pres = bit_ff;
      end
      new_age = is_miss ? '0 : hit_age_ff;
      victim  = emp_ff ? emp_idx_ff : best_idx_ff;
   end

   // single write port
   always_comb begin
      we = 1'b0;
      wa = idx_ff;
      wd = '0;
      if (cmd.clr) begin
         we = 1'b1;
      end else if (rvalid_ff) begin
         we = is_miss;
         wa = pidx_ff;
         wd = {r_addr, p2, g2};
      end else if (cmd.fin) begin
         if (hit_ff) begin
            we = is_miss || (type_ff == sfpt_pkg::REQ_READ_HIT) ||
                 (type_ff == sfpt_pkg::REQ_WRITE_UPG);
            wa = hit_idx_ff;
            wd = {line_ff, new_pres, new_age};
         end else begin
            we = is_miss;
            wa = victim;
            wd = {line_ff, bit_ff, {GW{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rvalid_ff    <= 1'b0;
         shift_ff     <= sfpt_pkg::TAG_SHIFT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rvalid_ff <= cmd.rd;
         if (csr_we) shift_ff <= csr_wdata;
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.clr || cmd.rd) begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         end
         if (cmd.fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) pidx_ff <= idx_ff;
      if (cmd.load) begin
         type_ff     <= in_type;
         bit_ff      <= {{(CORES-1){1'b0}}, 1'b1} << in_requester;
         line_ff     <= in_line_addr;
         wb_ff       <= in_writeback;
         hit_ff      <= 1'b0;
         emp_ff      <= 1'b0;
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else if (rvalid_ff) begin
         if (match && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_idx_ff  <= pidx_ff;
            hit_pres_ff <= p2;
            hit_age_ff  <= g2;
         end
         if ((p2 == '0) && !emp_ff) begin
            emp_ff     <= 1'b1;
            emp_idx_ff <= pidx_ff;
         end
         if (best_ff <= g2) begin
            best_ff     <= g2;
            best_idx_ff <= pidx_ff;
         end
      end
      if (cmd.fin) begin
         rsp_found_ff <= hit_ff;
         if (hit_ff) begin
            rsp_pres_ff <= is_miss || (type_ff == sfpt_pkg::REQ_READ_HIT) ||
                           (type_ff == sfpt_pkg::REQ_WRITE_UPG) ?
                           sfpt_pkg::PRES_W'(new_pres) : sfpt_pkg::PRES_W'(hit_pres_ff);
         end else begin
            rsp_pres_ff <= is_miss ? sfpt_pkg::PRES_W'(bit_ff) : '0;
         end
      end
   end

   assign sts.last     = (idx_ff == LAST_IDX);
   assign sts.rsp_busy = rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_presence = rsp_pres_ff;
endmodule
`default_nettype wire

// File: hw/rtl/snoop_filter_presence_table.sv
// top level of the snoop filter presence table
// a request passes the SCAN, DRAIN and FINAL states, then its response is registered
// one request at a time, none taken until the final write; the scan reads one entry a cycle
// the scan goes through the single-port-write table memory with registered read
// reset: synchronous; a clearing pass over all ENTRIES entries zeroes the table, req_tready low
// csr writes are taken at any time, tag_shift resets to 6
`timescale 1ns / 1ps
`default_nettype none
`include "snoop_filter_presence_table_defines.svh"
module snoop_filter_presence_table #(
   parameter int ENTRIES = 64,
   parameter int CORES   = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // requester[1:0], line_addr[33:2], writeback[34], zero
   input  wire logic [2:0]  req_tuser,  // req_type[2:0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // presence[3:0], zero
   output logic             rsp_tuser,  // found[0]
   // tag_shift register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_wdata   // tag_shift[4:0]
);
   sfpt_pkg::cmd_type cmd;
   sfpt_pkg::sts_type sts;
   logic [sfpt_pkg::PRES_W-1:0] presence;

   // config register always writable
   assign csr_ready = 1'b1;

   sfpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sfpt_dp #(
      .ENTRIES (ENTRIES),
      .CORES   (CORES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_type      (req_tuser),
      .in_requester (req_tdata[1:0]),
      .in_line_addr (req_tdata[33:2]),
      .in_writeback (req_tdata[34]),
      .csr_we       (csr_valid),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_found    (rsp_tuser),
      .rsp_presence (presence)
   );

   // presence in the low nibble, upper bits zero
   assign rsp_tdata = {4'b0, presence};

   // no request is taken while the table is being cleared
   `SFPT_ASSERT_NEVER(a_no_accept_in_clear, cmd.clr && req_tready)
   // the final write only goes out once the previous response is gone
   `SFPT_ASSERT_SAME(a_fin_rsp_free, cmd.fin, !rsp_tvalid)
   // a final write always produces a response transaction
   `SFPT_ASSERT_NEXT(a_fin_gives_rsp, cmd.fin, rsp_tvalid)
endmodule
`default_nettype wire

// File: verif/sfpt_checker.sv
// checker for the snoop filter presence table: predicts every response and compares
`timescale 1ns / 1ps
`default_nettype none
module sfpt_checker #(
   parameter int ENTRIES = 64,
   parameter int CORES   = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [4:0]  csr_wdata,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic                        found;
      logic [sfpt_pkg::PRES_W-1:0] presence;
   } lookup_result_type;

   logic [sfpt_pkg::ADDR_W-1:0]  tbl_addr [ENTRIES];
   logic [sfpt_pkg::PRES_W-1:0]  tbl_pres [ENTRIES];
   logic [sfpt_pkg::AGE_W-1:0]   tbl_age  [ENTRIES];
   logic [sfpt_pkg::SHIFT_W-1:0] shift_q;
   lookup_result_type            expected_q [$];

   function automatic int match_index(logic [sfpt_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_pres[i] != '0 && tbl_addr[i] == a) return i;
      return -1;
   endfunction

   task automatic apply_miss(logic is_store, logic [sfpt_pkg::PRES_W-1:0] bit_m,
                             logic [sfpt_pkg::ADDR_W-1:0] a, logic wb);
      int hit;
      int victim;
      logic [sfpt_pkg::AGE_W-1:0] best;
      if (wb)
         for (int i = 0; i < ENTRIES; i++)
            if (tbl_addr[i] != a && (tbl_addr[i] >> shift_q) == (a >> shift_q))
               tbl_pres[i] &= ~bit_m;
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_pres[i] != '0 && tbl_age[i] != '1) tbl_age[i]++;
      hit = match_index(a);
      if (hit >= 0) begin
         tbl_pres[hit] = is_store ? bit_m : (tbl_pres[hit] | bit_m);
         tbl_age[hit]  = '0;
         return;
      end
      victim = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (victim < 0 && tbl_pres[i] == '0) victim = i;
      if (victim < 0) begin
         best = '0;
         victim = 0;
         for (int i = 0; i < ENTRIES; i++)
            if (best <= tbl_age[i]) begin
               best = tbl_age[i];
               victim = i;
            end
      end
      tbl_addr[victim] = a;
      tbl_pres[victim] = bit_m;
      tbl_age[victim]  = '0;
   endtask

   task automatic predict_lookup(logic [2:0] kind, logic [1:0] core,
                                 logic [sfpt_pkg::ADDR_W-1:0] a, logic wb);
      lookup_result_type r;
      logic [sfpt_pkg::PRES_W-1:0] bit_m;
      int hit;
      bit_m = (int'(core) < CORES) ? sfpt_pkg::PRES_W'(1 << core) : '0;
      hit = match_index(a);
      r.found = hit >= 0;
      case (kind)
         sfpt_pkg::REQ_LOAD_MISS:  apply_miss(1'b0, bit_m, a, wb);
         sfpt_pkg::REQ_STORE_MISS: apply_miss(1'b1, bit_m, a, wb);
         sfpt_pkg::REQ_READ_HIT:   if (hit >= 0) tbl_pres[hit] |= bit_m;
         sfpt_pkg::REQ_WRITE_UPG:  if (hit >= 0) tbl_pres[hit] = bit_m;
         default: ;
      endcase
      hit = match_index(a);
      r.presence = (hit >= 0) ? tbl_pres[hit] : '0;
      expected_q.push_back(r);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      lookup_result_type e;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tbl_addr[i] = '0;
            tbl_pres[i] = '0;
            tbl_age[i]  = '0;
         end
         shift_q = sfpt_pkg::TAG_SHIFT_RST;
         expected_q.delete();
         fail_count = 0;
      end else begin
         // response first: a response never belongs to a request taken this edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response", int'(rsp_tdata), 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_tuser !== e.found)
                  report_mismatch("found", int'(rsp_tuser), int'(e.found));
               if (rsp_tdata !== {4'b0, e.presence})
                  report_mismatch("presence", int'(rsp_tdata), int'(e.presence));
            end
         end
         if (csr_valid && csr_ready) shift_q = csr_wdata;
         if (req_tvalid && req_tready)
            predict_lookup(req_tuser, req_tdata[1:0], req_tdata[33:2], req_tdata[34]);
      end
      pending = expected_q.size();
   end
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// testbench top: drives requests, csr writes and response back-pressure, gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam int ENTRIES = 64;
   localparam int LAT     = ENTRIES + 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          hold_req  = 0;   // long receiver hold-off requests
   int          hold_done = 0;   // long receiver hold-offs carried out

   // small address pool so hits, tag neighbors and evictions all happen
   logic [31:0] addr_pool [24];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   snoop_filter_presence_table #(.ENTRIES(ENTRIES), .CORES(4)) u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_wdata
   );

   sfpt_checker #(.ENTRIES(ENTRIES), .CORES(4)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_wdata,
      .fail_count, .pending
   );

   // one request transaction, with a random idle gap ahead of it
   task automatic send_req(logic [2:0] kind, logic [1:0] core, logic [31:0] a, logic wb);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no idling
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, wb, a, core};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering requests
   task automatic stop_req;
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every response is back, then let the block settle
   task automatic drain;
      stop_req();
      while (pending != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   // csr transaction, only while idle
   task automatic write_shift(logic [4:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random request: mostly pool addresses, some fully random
   task automatic random_req;
      logic [31:0] a;
      logic [2:0]  kind;
      a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 23)];
      kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      send_req(kind, 2'($urandom_range(0, 3)), a, 1'($urandom_range(0, 1)));
   endtask

   // response back-pressure, drawn per response
   always begin
      int wait_n;
      @(posedge clock);
      if (hold_req != hold_done) begin
         rsp_tready <= 1'b0;
         // long hold-off counted here while the sender keeps going
         repeat (6 * LAT) @(posedge clock);
         hold_done++;
      end else begin
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (wait_n != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
            rsp_tready <= 1'b0;
         end
      end
   end

   initial begin
      logic [4:0] shifts [5];
      shifts = '{5'd0, 5'd31, 5'd3, 5'd12, 5'd6};
      for (int i = 0; i < 24; i++)
         addr_pool[i] = (i < 12) ? {26'($urandom_range(0, 3)), 6'(i)} : $urandom;
      addr_pool[0] = 32'h0;
      addr_pool[1] = 32'hFFFF_FFFF;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table with address 0, every type, field extremes
      send_req(sfpt_pkg::REQ_READ_HIT, 2'd0, 32'h0, 1'b0);
      send_req(sfpt_pkg::REQ_LOAD_MISS, 2'd0, 32'h0, 1'b0);
      send_req(sfpt_pkg::REQ_LOAD_MISS, 2'd3, 32'h0, 1'b1);
      send_req(sfpt_pkg::REQ_LOOKUP, 2'd1, 32'h0, 1'b0);
      send_req(sfpt_pkg::REQ_STORE_MISS, 2'd2, 32'h0, 1'b0);
      send_req(sfpt_pkg::REQ_LOAD_MISS, 2'd1, 32'hFFFF_FFFF, 1'b0);
      send_req(sfpt_pkg::REQ_READ_HIT, 2'd2, 32'hFFFF_FFFF, 1'b0);
      send_req(sfpt_pkg::REQ_WRITE_UPG, 2'd3, 32'hFFFF_FFFF, 1'b0);
      send_req(sfpt_pkg::REQ_WRITE_UPG, 2'd0, 32'h1234_5678, 1'b0);
      // tag neighbor writeback clearing
      send_req(sfpt_pkg::REQ_LOAD_MISS, 2'd1, 32'h0000_0040, 1'b0);
      send_req(sfpt_pkg::REQ_LOAD_MISS, 2'd1, 32'h0000_0041, 1'b1);
      // request types outside the defined set
      send_req(3'd5, 2'd1, 32'h0000_0040, 1'b0);
      send_req(3'd7, 2'd1, 32'h0000_0041, 1'b1);
      send_req(3'd6, 2'd2, 32'hAAAA_5555, 1'b1);
      // overfill to force age-based replacement
      for (int i = 0; i < ENTRIES + 4; i++)
         send_req(sfpt_pkg::REQ_LOAD_MISS, 2'(i), 32'h8000_0000 + 32'(i) * 4096, 1'b0);
      drain();

      // random phases under several tag shift settings
      for (int p = 0; p < 5; p++) begin
         write_shift(shifts[p]);
         for (int n = 0; n < 220; n++) begin
            if (p == 1 && n == 20) hold_req++;
            if (n == 110) begin
               // sender pauses until everything is back
               stop_req();
               while (pending != 0) @(posedge clock);
            end
            random_req();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("[snoop_filter_presence_table] OK");
      end else begin
         $display("[snoop_filter_presence_table] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("[snoop_filter_presence_table] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
